/* hdl/perd_pkg.sv */
// shared types and constants for the per-process event rate detector
package perd_pkg;

  // field widths
  localparam int PID_W = 32;
  localparam int UID_W = 32;
  localparam int TS_W  = 64;
  localparam int CNT_W = 32;
  localparam int WIN_W = 40;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLONE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd2;

  localparam logic [CNT_W-1:0] OPEN_THRESHOLD_RST  = 32'd100;
  localparam logic [CNT_W-1:0] CLONE_THRESHOLD_RST = 32'd50;
  localparam logic [WIN_W-1:0] WINDOW_LENGTH_RST   = 40'd1000000000;

  // event kinds
  localparam logic KIND_OPEN  = 1'b0;
  localparam logic KIND_CLONE = 1'b1;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_EMIT
  } perd_state_t;

  // one table entry beside its tag
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [TS_W-1:0]  start;
  } perd_entry_t;

  // tag search outcome
  typedef struct packed {
    logic done;
    logic found;
    logic taken;
  } perd_srch_t;

  // entry update outcome
  typedef struct packed {
    logic             done;
    logic             fire;
    logic [CNT_W-1:0] count;
  } perd_upd_t;

endpackage

/* hdl/perd_tag_search.sv */
// tag memory and sequential scan that finds or allocates a process slot
module perd_tag_search #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               kind,
  input  logic [perd_pkg::PID_W-1:0]         pid,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0] fill,
  output perd_pkg::perd_srch_t               status,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   slot
);
  import perd_pkg::*;

  localparam int SW = $clog2(TABLE_ENTRIES);
  localparam int FW = $clog2(TABLE_ENTRIES + 1);
  localparam int MEM_DEPTH = 2 * (2 ** SW);
  localparam logic [FW-1:0] FULL_FILL = FW'(TABLE_ENTRIES);

  logic [PID_W-1:0] tag_mem [MEM_DEPTH];
  logic [PID_W-1:0] tag_rdata_r;

  logic          busy_r;
  logic          pend_r;
  logic [FW-1:0] scan_r;
  logic [SW-1:0] pend_slot_r;

  logic rd_en;
  logic match;
  logic exhausted;
  logic done;
  logic taken;

  // scan control: one tag read per cycle, compare in the cycle after the read
  assign rd_en     = busy_r && (scan_r < fill);
  assign match     = busy_r && pend_r && (tag_rdata_r == pid);
  assign exhausted = busy_r && !pend_r && !rd_en;
  assign done      = match || exhausted;
  assign taken     = exhausted && (fill != FULL_FILL);

  assign status.done  = done;
  assign status.found = match;
  assign status.taken = taken;
  assign slot         = match ? pend_slot_r : fill[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      scan_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      pend_r <= 1'b0;
      scan_r <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (busy_r) begin
      pend_r <= rd_en;
      if (rd_en) begin
        scan_r <= scan_r + FW'(1);
      end
    end
  end

  // slot of the tag in flight
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_slot_r <= scan_r[SW-1:0];
    end
  end

  // tag memory: allocation write, scan read
  always_ff @(posedge clk) begin
    if (taken) begin
      tag_mem[{kind, fill[SW-1:0]}] <= pid;
    end
    if (rd_en) begin
      tag_rdata_r <= tag_mem[{kind, scan_r[SW-1:0]}];
    end
  end

endmodule

/* hdl/perd_entry_update.sv */
// entry memory with read, window check, saturating count and write-back
module perd_entry_update #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             kind,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] slot,
  input  logic                             is_new,
  input  logic [perd_pkg::TS_W-1:0]        now,
  input  logic [perd_pkg::WIN_W-1:0]       window,
  input  logic [perd_pkg::CNT_W-1:0]       threshold,
  output perd_pkg::perd_upd_t              status
);
  import perd_pkg::*;

  localparam int SW = $clog2(TABLE_ENTRIES);
  localparam int MEM_DEPTH = 2 * (2 ** SW);

  perd_entry_t ent_mem [MEM_DEPTH];
  perd_entry_t ent_rdata_r;

  logic          s1_r;
  logic          s2_r;
  logic [SW:0]   addr_r;
  logic          new_r;
  logic [CNT_W-1:0] cnt_r;
  logic [TS_W-1:0]  start_r;

  logic [CNT_W-1:0] base_cnt;
  logic [TS_W-1:0]  base_start;
  logic [TS_W-1:0]  elapsed;
  logic             restart;
  logic             at_max;
  logic [CNT_W-1:0] cnt_inc;

  // stage 1: window check on the read entry (a new entry reads as zero)
  assign base_cnt   = new_r ? '0 : ent_rdata_r.count;
  assign base_start = new_r ? '0 : ent_rdata_r.start;
  assign elapsed    = now - base_start;
  assign restart    = elapsed > {{(TS_W-WIN_W){1'b0}}, window};

  // stage 2: saturating increment and threshold compare
  assign at_max  = (cnt_r == {CNT_W{1'b1}});
  assign cnt_inc = at_max ? cnt_r : cnt_r + CNT_W'(1);

  assign status.done  = s2_r;
  assign status.fire  = s2_r && !at_max && (cnt_inc == threshold);
  assign status.count = cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
      s2_r <= 1'b0;
    end else begin
      s1_r <= start;
      s2_r <= s1_r;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= {kind, slot};
      new_r  <= is_new;
    end
    if (s1_r) begin
      cnt_r   <= restart ? '0 : base_cnt;
      start_r <= restart ? now : base_start;
    end
  end

  // entry memory: read on start, write back in stage 2
  always_ff @(posedge clk) begin
    if (start) begin
      ent_rdata_r <= ent_mem[{kind, slot}];
    end
    if (s2_r) begin
      ent_mem[addr_r] <= '{count: cnt_inc, start: start_r};
    end
  end

endmodule

/* hdl/per_process_event_rate_detector_core.sv */
// top level of the per-process event rate detector
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | mode, process_id, user_id, timestamp
//   out_    | output    | out_valid / out_ready | alert pid, uid, time, kind, count
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_wdata
//
// one event at a time: a process found in slot p of its kind's table is found after tag
// reads of slots 0 to p, an absent one after reads of all n slots in use (none when the
// table is empty), then takes a free slot or is dropped when the table is full; one tag
// read per cycle; an alert passes through an emit state that loads the output register
// reset is synchronous; tables come up empty through per-kind fill counts
// a held alert stalls the next event only when a new alert is ready to load
module per_process_event_rate_detector_core #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [perd_pkg::PID_W-1:0]        in_process_id,
  input  logic [perd_pkg::UID_W-1:0]        in_user_id,
  input  logic [perd_pkg::TS_W-1:0]         in_timestamp,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [perd_pkg::PID_W-1:0]        out_alert_process_id,
  output logic [perd_pkg::UID_W-1:0]        out_alert_user_id,
  output logic [perd_pkg::TS_W-1:0]         out_alert_time,
  output logic                              out_anomaly_kind,
  output logic [perd_pkg::CNT_W-1:0]        out_event_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [perd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [perd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import perd_pkg::*;

  localparam int SW = $clog2(TABLE_ENTRIES);
  localparam int FW = $clog2(TABLE_ENTRIES + 1);

  perd_state_t state_r, state_nxt;

  // configuration registers
  logic [CNT_W-1:0] open_thr_r;
  logic [CNT_W-1:0] clone_thr_r;
  logic [WIN_W-1:0] window_r;

  // fill counts per kind
  logic [FW-1:0] open_fill_r;
  logic [FW-1:0] clone_fill_r;
  logic [FW-1:0] fill_sel;

  // current transaction
  logic             kind_r;
  logic [PID_W-1:0] pid_r;
  logic [UID_W-1:0] uid_r;
  logic [TS_W-1:0]  ts_r;
  logic [CNT_W-1:0] hit_cnt_r;

  // output register
  logic             out_valid_r;
  logic [PID_W-1:0] out_pid_r;
  logic [UID_W-1:0] out_uid_r;
  logic [TS_W-1:0]  out_ts_r;
  logic             out_kind_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic          in_accept;
  logic          srch_start;
  logic          upd_start;
  logic          out_load;
  perd_srch_t    srch;
  perd_upd_t     upd;
  logic [SW-1:0] srch_slot;
  logic [CNT_W-1:0] thr_sel;

  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign fill_sel  = (kind_r == KIND_CLONE) ? clone_fill_r : open_fill_r;
  assign thr_sel   = (kind_r == KIND_CLONE) ? clone_thr_r : open_thr_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    srch_start = 1'b0;
    upd_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          srch_start = 1'b1;
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch.done) begin
          if (srch.found || srch.taken) begin
            upd_start = 1'b1;
            state_nxt = ST_UPDATE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_UPDATE: begin
        if (upd.done) begin
          state_nxt = upd.fire ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_thr_r  <= OPEN_THRESHOLD_RST;
      clone_thr_r <= CLONE_THRESHOLD_RST;
      window_r    <= WINDOW_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OPEN_THRESHOLD:  open_thr_r  <= cfg_wdata[CNT_W-1:0];
        CFG_CLONE_THRESHOLD: clone_thr_r <= cfg_wdata[CNT_W-1:0];
        CFG_WINDOW_LENGTH:   window_r    <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // fill counts grow when a slot is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_fill_r  <= '0;
      clone_fill_r <= '0;
    end else if (srch.taken) begin
      if (kind_r == KIND_CLONE) begin
        clone_fill_r <= clone_fill_r + FW'(1);
      end else begin
        open_fill_r <= open_fill_r + FW'(1);
      end
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_mode;
      pid_r  <= in_process_id;
      uid_r  <= in_user_id;
      ts_r   <= in_timestamp;
    end
    if (upd.done) begin
      hit_cnt_r <= upd.count;
    end
  end

  // alert output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pid_r  <= pid_r;
      out_uid_r  <= uid_r;
      out_ts_r   <= ts_r;
      out_kind_r <= kind_r;
      out_cnt_r  <= hit_cnt_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_alert_process_id = out_pid_r;
  assign out_alert_user_id    = out_uid_r;
  assign out_alert_time       = out_ts_r;
  assign out_anomaly_kind     = out_kind_r;
  assign out_event_count      = out_cnt_r;

  perd_tag_search #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_tag_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (srch_start),
    .kind   (kind_r),
    .pid    (pid_r),
    .fill   (fill_sel),
    .status (srch),
    .slot   (srch_slot)
  );

  perd_entry_update #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_entry_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (upd_start),
    .kind      (kind_r),
    .slot      (srch_slot),
    .is_new    (srch.taken),
    .now       (ts_r),
    .window    (window_r),
    .threshold (thr_sel),
    .status    (upd)
  );

endmodule

/* hdl/perd_checker.sv */
// port-level checks for the rate detector, bound to the top level
module perd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [perd_pkg::PID_W-1:0]  out_alert_process_id,
  input logic [perd_pkg::UID_W-1:0]  out_alert_user_id,
  input logic [perd_pkg::TS_W-1:0]   out_alert_time,
  input logic                        out_anomaly_kind,
  input logic [perd_pkg::CNT_W-1:0]  out_event_count
);
  import perd_pkg::*;

  // a pending alert stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("alert dropped before it was taken");

  // a stalled alert keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_alert_process_id) &&
      $stable(out_alert_user_id) && $stable(out_alert_time) &&
      $stable(out_anomaly_kind) && $stable(out_event_count))
    else $error("alert payload changed while stalled");

  // reset leaves no alert pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("alert pending right after reset");

  // an alert always reports a nonzero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_count != '0)
    else $error("alert with zero event count");

  // one event at a time: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second event taken while the first is in flight");

endmodule

bind per_process_event_rate_detector_core perd_checker u_perd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_alert_process_id (out_alert_process_id),
  .out_alert_user_id    (out_alert_user_id),
  .out_alert_time       (out_alert_time),
  .out_anomaly_kind     (out_anomaly_kind),
  .out_event_count      (out_event_count)
);

/* tb/sv/tb_top.sv */
// self-checking testbench for the per-process event rate detector core
`timescale 1ns / 1ps

module tb_top;
  import perd_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int GAP_LIMIT     = 14;
  localparam int HOLD_CYCLES   = 1500;
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 64;
  localparam int STALL_LIMIT   = 20000;
  localparam int POOL_SIZE     = 6;
  localparam int PHASE_ITEMS   = 100;

  // no register lives at this index
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  // one alert as seen on the result channel
  typedef struct {
    logic [PID_W-1:0] pid;
    logic [UID_W-1:0] uid;
    logic [TS_W-1:0]  stamp;
    logic             kind;
    logic [CNT_W-1:0] count;
  } alert_rec_t;

  // per-kind rate tables and the alerts they are due to raise
  class storm_tracker;
    bit               used   [2][TABLE_ENTRIES];
    bit [PID_W-1:0]   owner  [2][TABLE_ENTRIES];
    bit [CNT_W-1:0]   hits   [2][TABLE_ENTRIES];
    bit [TS_W-1:0]    opened [2][TABLE_ENTRIES];
    bit [CNT_W-1:0]   open_limit  = OPEN_THRESHOLD_RST;
    bit [CNT_W-1:0]   clone_limit = CLONE_THRESHOLD_RST;
    bit [WIN_W-1:0]   window      = WINDOW_LENGTH_RST;
    alert_rec_t       due_alerts[$];
    int               errors;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_OPEN_THRESHOLD: open_limit = data[CNT_W-1:0];
        CFG_CLONE_THRESHOLD: clone_limit = data[CNT_W-1:0];
        CFG_WINDOW_LENGTH: window = data[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int vacancies(logic kind);
      int n;
      n = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) if (!used[int'(kind)][i]) n++;
      return n;
    endfunction

    // one accepted event: lookup or take a slot, window check, count, threshold
    function void note_event(logic kind, logic [PID_W-1:0] pid, logic [UID_W-1:0] uid,
                             logic [TS_W-1:0] now);
      int               k;
      int               slot;
      int               vacant;
      logic [CNT_W-1:0] prior;
      logic [CNT_W-1:0] limit;
      alert_rec_t       rec;
      k = int'(kind);
      slot = -1;
      vacant = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (used[k][i]) begin
          if (owner[k][i] == pid) begin
            slot = i;
            break;
          end
        end else if (vacant < 0) vacant = i;
      end
      if (slot < 0) begin
        // table full: the event is dropped
        if (vacant < 0) return;
        slot = vacant;
        used[k][slot] = 1'b1;
        owner[k][slot] = pid;
        hits[k][slot] = '0;
        opened[k][slot] = '0;
      end
      // wrapping elapsed time
      if (now - opened[k][slot] > {24'd0, window}) begin
        hits[k][slot] = '0;
        opened[k][slot] = now;
      end
      prior = hits[k][slot];
      if (prior != {CNT_W{1'b1}}) hits[k][slot] = prior + 1'b1;
      limit = (kind == KIND_CLONE) ? clone_limit : open_limit;
      if (hits[k][slot] != prior && hits[k][slot] == limit) begin
        rec.pid = pid;
        rec.uid = uid;
        rec.stamp = now;
        rec.kind = kind;
        rec.count = hits[k][slot];
        due_alerts.push_back(rec);
      end
    endfunction

    function void check_alert(alert_rec_t got);
      alert_rec_t want;
      if (due_alerts.size() == 0) begin
        $error("alert with none due: alert_process_id %h", got.pid);
        errors++;
        return;
      end
      want = due_alerts.pop_front();
      if (got.pid !== want.pid) begin
        $error("alert_process_id: expected %h, actual %h", want.pid, got.pid);
        errors++;
      end
      if (got.uid !== want.uid) begin
        $error("alert_user_id: expected %h, actual %h", want.uid, got.uid);
        errors++;
      end
      if (got.stamp !== want.stamp) begin
        $error("alert_time: expected %h, actual %h", want.stamp, got.stamp);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $error("anomaly_kind: expected %b, actual %b", want.kind, got.kind);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("event_count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [PID_W-1:0]      in_process_id;
  logic [UID_W-1:0]      in_user_id;
  logic [TS_W-1:0]       in_timestamp;
  logic                  out_valid;
  logic                  out_ready;
  logic [PID_W-1:0]      out_alert_process_id;
  logic [UID_W-1:0]      out_alert_user_id;
  logic [TS_W-1:0]       out_alert_time;
  logic                  out_anomaly_kind;
  logic [CNT_W-1:0]      out_event_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  storm_tracker          tracker = new;
  int                    src_gap_max;
  int                    sink_gap_max;
  bit                    sink_hold_req;
  logic [TS_W-1:0]       clock_ns;
  logic [PID_W-1:0]      pid_pool [POOL_SIZE];

  per_process_event_rate_detector_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_process_id       (in_process_id),
    .in_user_id          (in_user_id),
    .in_timestamp        (in_timestamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_alert_process_id(out_alert_process_id),
    .out_alert_user_id   (out_alert_user_id),
    .out_alert_time      (out_alert_time),
    .out_anomaly_kind    (out_anomaly_kind),
    .out_event_count     (out_event_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // monitor every transaction at the rising edge
  always @(posedge clk) begin
    alert_rec_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_wdata);
      if (out_valid && out_ready) begin
        got.pid = out_alert_process_id;
        got.uid = out_alert_user_id;
        got.stamp = out_alert_time;
        got.kind = out_anomaly_kind;
        got.count = out_event_count;
        tracker.check_alert(got);
      end
      if (in_valid && in_ready)
        tracker.note_event(in_mode, in_process_id, in_user_id, in_timestamp);
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("per_process_event_rate_detector_core regression: fail");
    $finish;
  end

  // alert sink with random back-pressure and one long hold-off
  initial begin : alert_sink
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        sink_hold_req = 1'b0;
      end
      gap = $urandom_range(0, sink_gap_max);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // one event transaction, called at a falling edge
  task automatic send_event(input logic mode, input logic [PID_W-1:0] pid,
                            input logic [UID_W-1:0] uid, input logic [TS_W-1:0] ts);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = mode;
    in_process_id = pid;
    in_user_id = uid;
    in_timestamp = ts;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender stops until every due alert has arrived
  task automatic wait_for_alerts();
    in_valid = 1'b0;
    while (tracker.due_alerts.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // registers change only once the block has gone idle
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] open_thr,
                             input logic [CFG_DATA_W-1:0] clone_thr,
                             input logic [CFG_DATA_W-1:0] window);
    wait_for_alerts();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_put(CFG_OPEN_THRESHOLD, open_thr);
    cfg_put(CFG_CLONE_THRESHOLD, clone_thr);
    cfg_put(CFG_WINDOW_LENGTH, window);
    cfg_put(CFG_UNUSED_INDEX, CFG_DATA_W'({$urandom(), $urandom()}));
    cfg_valid = 1'b0;
  endtask

  task automatic new_pool();
    foreach (pid_pool[i]) pid_pool[i] = $urandom();
  endtask

  // mostly known processes on a running clock, some strangers and wild timestamps
  task automatic random_event(input bit [31:0] step_max);
    logic             mode;
    logic [PID_W-1:0] pid;
    logic [TS_W-1:0]  ts;
    mode = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 85) pid = pid_pool[$urandom_range(0, POOL_SIZE-1)];
    else pid = $urandom();
    if ($urandom_range(0, 19) == 0) begin
      ts = {$urandom(), $urandom()};
    end else begin
      clock_ns += TS_W'($urandom_range(0, step_max));
      ts = clock_ns;
    end
    send_event(mode, pid, $urandom(), ts);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] open_thr,
                           input logic [CFG_DATA_W-1:0] clone_thr,
                           input logic [CFG_DATA_W-1:0] window,
                           input bit [31:0] step_max, input bit random_base,
                           input int gap_in, input int gap_out, input bit hold);
    reconfigure(open_thr, clone_thr, window);
    src_gap_max = gap_in;
    sink_gap_max = gap_out;
    clock_ns = random_base ? {$urandom(), $urandom()} : '0;
    new_pool();
    sink_hold_req = hold;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2) wait_for_alerts();
      random_event(step_max);
    end
  endtask

  // take every free slot of one table
  task automatic fill_table(input logic kind);
    while (tracker.vacancies(kind) > 0) begin
      clock_ns += TS_W'($urandom_range(0, 50));
      send_event(kind, $urandom(), $urandom(), clock_ns);
    end
  endtask

  // stimulus
  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = KIND_OPEN;
    in_process_id = '0;
    in_user_id = '0;
    in_timestamp = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_OPEN_THRESHOLD;
    cfg_wdata = '0;
    src_gap_max = GAP_LIMIT;
    sink_gap_max = GAP_LIMIT;
    sink_hold_req = 1'b0;
    clock_ns = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // window boundary, earlier timestamp, separate tables, upper config bits masked
    reconfigure({8'hFF, 32'd2}, 40'd1, 40'd1000);
    send_event(KIND_OPEN, 32'h0, 32'h0, 64'd0);
    send_event(KIND_OPEN, 32'h0, 32'hFFFF_FFFF, 64'd500);
    send_event(KIND_OPEN, 32'h0, 32'h1, 64'd1500);
    send_event(KIND_OPEN, 32'h0, 32'h2, 64'd2500);
    send_event(KIND_OPEN, 32'h0, 32'h3, 64'd0);
    send_event(KIND_CLONE, 32'hFFFF_FFFF, 32'h1234_5678, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(KIND_CLONE, 32'hFFFF_FFFF, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_event(KIND_CLONE, 32'h0, 32'h5, 64'd5);
    send_event(KIND_OPEN, 32'h1, 32'hAAAA_5555, 64'd1000);
    send_event(KIND_OPEN, 32'h1, 32'h5555_AAAA, 64'd1001);

    // zero thresholds never fire, widest window
    reconfigure(40'd0, 40'd0, 40'hFF_FFFF_FFFF);
    send_event(KIND_OPEN, 32'h0, 32'h7, 64'd10);
    send_event(KIND_OPEN, 32'h0, 32'h7, 64'd11);
    send_event(KIND_CLONE, 32'h0, 32'h8, 64'd12);
    send_event(KIND_CLONE, 32'hFFFF_FFFF, 32'h9, 64'h8000_0000_0000_0000);

    // zero window: repeated timestamps keep counting, a later one restarts
    reconfigure(40'd1, 40'd3, 40'd0);
    repeat (3) send_event(KIND_OPEN, 32'h2, $urandom(), 64'd100);
    repeat (3) send_event(KIND_CLONE, 32'h3, $urandom(), 64'd7);
    send_event(KIND_OPEN, 32'h2, $urandom(), 64'd101);

    // random phases over several settings
    run_phase(40'd3, 40'd5, 40'd2000, 32'd60, 1'b0, GAP_LIMIT, GAP_LIMIT, 1'b0);
    run_phase(40'd1, 40'd1, 40'd0, 32'd3, 1'b1, 0, GAP_LIMIT, 1'b1);
    run_phase({8'hA5, 32'd2}, 40'd4, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              GAP_LIMIT, 0, 1'b0);
    run_phase(40'd5, 40'd2, 40'd10000, 32'd300, 1'b0, 0, 0, 1'b0);
    run_phase(40'hFFFF_FFFF, 40'd1, 40'd500, 32'd100, 1'b1, GAP_LIMIT, GAP_LIMIT, 1'b0);
    run_phase(40'd4, 40'd6, 40'd1000000000, 32'd20000000, 1'b1,
              GAP_LIMIT, GAP_LIMIT, 1'b0);

    // full tables: known processes keep counting, strangers are dropped
    reconfigure(40'd3, 40'd3, 40'd5000);
    src_gap_max = GAP_LIMIT;
    sink_gap_max = GAP_LIMIT;
    clock_ns = '0;
    new_pool();
    foreach (pid_pool[i]) begin
      send_event(KIND_OPEN, pid_pool[i], $urandom(), clock_ns);
      send_event(KIND_CLONE, pid_pool[i], $urandom(), clock_ns);
    end
    fill_table(KIND_OPEN);
    fill_table(KIND_CLONE);
    for (int n = 0; n < PHASE_ITEMS; n++) random_event(32'd50);

    // drain and let the last event finish
    wait_for_alerts();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.errors == 0 && tracker.due_alerts.size() == 0)
      $display("per_process_event_rate_detector_core regression: pass");
    else
      $display("per_process_event_rate_detector_core regression: fail");
    $finish;
  end

endmodule
